[rtl/mmc_pkg.sv]
// ----------------------------------------------------------------------------
// mmc_pkg: shared types and constants for the modulo-65535 checksum block
// Mode codes, register indexes, derived widths and the modulo fold function.
// ----------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

  // largest hunk table count accepted in weighted mode
  localparam int unsigned MAX_TABLE_ENTRIES = 64;

  localparam logic [15:0] MODULUS      = 16'hffff;
  localparam int unsigned SKIP_OFFSET  = 34;
  localparam int unsigned TABLE_START  = 20;
  localparam int unsigned ENTRY_BYTES  = 12;
  localparam int unsigned WEIGHT_START = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SUM  = 2'd2;

  // derived datapath widths
  localparam int unsigned MAX_WEIGHT   = ENTRY_BYTES * MAX_TABLE_ENTRIES;
  localparam int unsigned WEIGHT_W_RAW = $clog2(MAX_WEIGHT + 1);
  localparam int unsigned WEIGHT_W     = (WEIGHT_W_RAW > 5) ? WEIGHT_W_RAW : 5;
  localparam int unsigned PROD_W       = 8 + WEIGHT_W;
  localparam int unsigned ADDEND_W     = (PROD_W > 16) ? PROD_W : 16;
  localparam int unsigned ACC_W        = ADDEND_W + 1;
  localparam int unsigned TEND_W       = 20;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_WEIGHT = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] table_entries;
    logic [15:0] expected_sum;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        matches_res;
    logic        rejected;
  } res_t;

  // reduce a sum of a value below 65535 and an addend modulo 65535
  function automatic logic [15:0] fold_mod(input logic [ACC_W-1:0] x);
    logic [16:0] t;
    logic [15:0] u;
    t = {1'b0, x[15:0]} + 17'(x[ACC_W-1:16]);
    u = t[15:0] + 16'(t[16]);
    if (u == MODULUS) begin
      u = 16'd0;
    end
    return u;
  endfunction

endpackage

`default_nettype wire

[rtl/mmc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mmc_cfg_regs: configuration register file
// Holds mode, hunk table count and expected sum; writes to unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mmc_pkg::cfg_t                       cfg_o
);
  import mmc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:          cfg_d.mode          = mode_e'(cfg_data_i[1:0]);
        REG_TABLE_ENTRIES: cfg_d.table_entries = cfg_data_i;
        REG_EXPECTED_SUM:  cfg_d.expected_sum  = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_BYTE, table_entries: 16'd0, expected_sum: 16'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/mmc_in_stage.sv]
// ----------------------------------------------------------------------------
// mmc_in_stage: input register
// Captures one item per cycle unless stalled and holds it until the accumulator takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_in_stage (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire mmc_pkg::in_item_t item_i,
  input  wire logic         take_i,
  output logic              valid_o,
  output mmc_pkg::in_item_t item_o
);
  import mmc_pkg::*;

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;
  logic     accept;

  // stall only while a held item cannot move on
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[rtl/mmc_accum.sv]
// ----------------------------------------------------------------------------
// mmc_accum: checksum accumulator
// Adds the held byte, a byte pair or a weighted byte by mode modulo 65535
// into the running sum and forms the result on the last byte of a stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_accum (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire mmc_pkg::cfg_t cfg_i,
  input  wire logic         valid_i,
  input  wire mmc_pkg::in_item_t item_i,
  input  wire logic         out_free_i,
  output logic              take_o,
  output logic              res_valid_o,
  output mmc_pkg::res_t     res_o
);
  import mmc_pkg::*;

  logic [15:0]         sum_q, sum_d;
  logic [31:0]         offset_q, offset_d;
  logic [7:0]          held_q, held_d;

  logic [TEND_W-1:0]   table_end;
  logic                over;
  logic                in_head;
  logic                in_table;
  logic [WEIGHT_W-1:0] weight;
  logic [PROD_W-1:0]   product;
  logic [ADDEND_W-1:0] addend;
  logic                add_en;
  logic [15:0]         sum_new;
  logic                short_stream;
  logic                rej;
  logic [15:0]         final_sum;

  // a last item waits for room in the output register
  assign take_o      = valid_i && (!item_i.is_last || out_free_i);
  assign res_valid_o = take_o && item_i.is_last;

  // weighted mode region decode
  assign table_end = TEND_W'(TABLE_START)
                   + {1'b0, cfg_i.table_entries, 3'b000}
                   + {2'b00, cfg_i.table_entries, 2'b00};
  assign over      = cfg_i.table_entries > 16'(MAX_TABLE_ENTRIES);
  assign in_head   = (offset_q >= 32'(WEIGHT_START)) && (offset_q < 32'(TABLE_START));
  assign in_table  = (offset_q >= 32'(TABLE_START)) && !over
                   && (offset_q < 32'(table_end));

  // weight select and the single multiplier
  always_comb begin
    if (in_head) begin
      weight = WEIGHT_W'(offset_q[4:0]);
    end else begin
      weight = WEIGHT_W'(offset_q - 32'(TABLE_START - 1));
    end
  end

  assign product = PROD_W'(item_i.data_byte) * PROD_W'(weight);

  // addend and held byte by mode
  always_comb begin
    addend = '0;
    add_en = 1'b0;
    held_d = held_q;
    unique case (cfg_i.mode)
      MODE_WORD: begin
        if (!offset_q[0]) begin
          held_d = item_i.data_byte;
        end else if (offset_q != 32'(SKIP_OFFSET + 1)) begin
          addend = ADDEND_W'({held_q, item_i.data_byte});
          add_en = 1'b1;
        end
      end
      MODE_WEIGHT: begin
        addend = ADDEND_W'(product);
        add_en = in_head || in_table;
      end
      default: begin
        addend = ADDEND_W'(item_i.data_byte);
        add_en = 1'b1;
      end
    endcase
  end

  assign sum_new = add_en ? fold_mod(ACC_W'(sum_q) + ACC_W'(addend)) : sum_q;

  // result forming, with the weighted mode rejects
  assign short_stream = ({1'b0, offset_q} + 33'd1) < 33'(table_end);
  assign rej          = (cfg_i.mode == MODE_WEIGHT) && (over || short_stream);
  assign final_sum    = rej ? 16'd0 : sum_new;

  assign res_o.checksum    = final_sum;
  assign res_o.matches_res = final_sum == cfg_i.expected_sum;
  assign res_o.rejected    = rej;

  // stream state update, cleared after the last item
  always_comb begin
    sum_d    = sum_q;
    offset_d = offset_q;
    if (take_o) begin
      if (item_i.is_last) begin
        sum_d    = 16'd0;
        offset_d = 32'd0;
      end else begin
        sum_d = sum_new;
        if (offset_q != '1) begin
          offset_d = offset_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= 16'd0;
      offset_q <= 32'd0;
      held_q   <= 8'd0;
    end else begin
      sum_q    <= sum_d;
      offset_q <= offset_d;
      if (take_o) begin
        held_q <= item_i.is_last ? 8'd0 : held_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_sum_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q != MODULUS)
    else $error("running sum left unreduced");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (sum_q == 16'd0) && (offset_q == 32'd0) && (held_q == 8'd0))
    else $error("stream state not cleared after last item");

  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && !item_i.is_last && offset_q != '1) |=> offset_q == $past(offset_q) + 32'd1)
    else $error("byte offset did not advance");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.rejected) |-> res_o.checksum == 16'd0)
    else $error("rejected result carries a nonzero sum");

  a_reject_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cfg_i.mode != MODE_WEIGHT) |-> !res_o.rejected)
    else $error("reject outside weighted mode");
`endif

endmodule

`default_nettype wire

[rtl/mmc_out_stage.sv]
// ----------------------------------------------------------------------------
// mmc_out_stage: output register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_out_stage (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     res_valid_i,
  input  wire mmc_pkg::res_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output mmc_pkg::res_t res_o
);
  import mmc_pkg::*;

  logic valid_q;
  logic valid_d;
  res_t res_q;

  // room for a new result when empty or draining this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[rtl/multi_mode_mod65535_checksum.sv]
// ----------------------------------------------------------------------------
// multi_mode_mod65535_checksum: multi-mode additive checksum modulo 65535
// Byte sum, word sum skipping the word at offset 34, or weighted header sum
// over a byte stream; one result item per stream, on its last byte.
// ----------------------------------------------------------------------------
// One byte item is taken every clock cycle when the output side keeps up.
// A byte is registered at the input and added into the running sum from that
// register; the result of a last byte is loaded into the output register at
// the edge that takes it, so a result is offered in the cycle after its last
// byte is taken. The rate is set by the accumulate loop: one 8-bit by weight
// multiply and a two-step modulo-65535 fold on the running sum per cycle. Only
// a last byte waits on a full, stalled output register; other bytes keep
// flowing. No clearing pass is needed after reset. Configuration should be
// written between streams.
`default_nettype none

module multi_mode_mod65535_checksum (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           is_last_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [15:0]                         checksum_o,
  output logic                                matches_res_o,
  output logic                                rejected_o
);
  import mmc_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     take;
  logic     out_free;
  logic     res_valid;
  res_t     res;
  res_t     out_res;

  assign in_item.data_byte = data_byte_i;
  assign in_item.is_last   = is_last_i;

  mmc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mmc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  mmc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (held_valid),
    .item_i      (held_item),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mmc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign checksum_o    = out_res.checksum;
  assign matches_res_o = out_res.matches_res;
  assign rejected_o    = out_res.rejected;

endmodule

`default_nettype wire
